// ----- rtl/core/rv32ie_pkg.sv -----
// Shared constants, types and encodings of the RV32IM execute core.
// Used by rv32ie_div and rv32im_instruction_execute_core; depends on nothing.
package rv32ie_pkg;

	localparam int unsigned MEM_BYTES = 16384;
	localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);
	localparam int unsigned OUT_W     = 208;

	localparam logic [31:0] RESET_PC   = 32'h8000_0000;
	localparam logic [31:0] RESET_BASE = 32'h8000_0000;

	localparam logic CFG_START_PC = 1'b0;
	localparam logic CFG_MEM_BASE = 1'b1;

	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_JAL    = 7'h6f;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_SYSTEM = 7'h73;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_MULD = 7'h01;
	localparam logic [6:0] F7_ALT  = 7'h20;

	localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;
	localparam logic [31:0] INSN_ECALL  = 32'h0000_0073;
	localparam logic [31:0] INSN_MRET   = 32'h3020_0073;

	localparam logic [11:0] CSR_MSTATUS = 12'h300;
	localparam logic [11:0] CSR_MTVEC   = 12'h305;
	localparam logic [11:0] CSR_MEPC    = 12'h341;
	localparam logic [11:0] CSR_MCAUSE  = 12'h342;

	localparam logic [4:0] REG_A0 = 5'd10;
	localparam logic [4:0] REG_A7 = 5'd17;

	typedef enum logic [1:0] {
		CS_MSTATUS,
		CS_MTVEC,
		CS_MEPC,
		CS_MCAUSE
	} csr_sel_t;

	typedef enum logic [2:0] {
		SRC_ALU,
		SRC_LOAD,
		SRC_MUL_LO,
		SRC_MUL_HI,
		SRC_QUO,
		SRC_REM
	} res_src_t;

	typedef struct packed {
		logic        start;
		logic        sgn;
		logic [31:0] a;
		logic [31:0] b;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
		logic [31:0] rem;
	} div_rsp_t;

endpackage

// ----- rtl/core/rv32ie_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rv32ie_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/rv32ie_div.sv -----
// Iterative 32-bit divider, one quotient bit a cycle, RISC-V signed and zero rules.
// Depends on rv32ie_pkg.
module rv32ie_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rv32ie_pkg::div_req_t req,
	output rv32ie_pkg::div_rsp_t rsp
);
	import rv32ie_pkg::*;

	logic [31:0] rem_q, quo_q, dvs_q, dvd_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q, nq_q, nr_q, bz_q;
	logic [32:0] trial;
	logic        na, nb;

	assign na    = req.sgn & req.a[31];
	assign nb    = req.sgn & req.b[31];
	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= na ? (32'd0 - req.a) : req.a;
			dvs_q <= nb ? (32'd0 - req.b) : req.b;
			dvd_q <= req.a;
			nq_q  <= na ^ nb;
			nr_q  <= na;
			bz_q  <= (req.b == '0);
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = bz_q ? '1 : (nq_q ? (32'd0 - quo_q) : quo_q);
	assign rsp.rem  = bz_q ? dvd_q : (nr_q ? (32'd0 - rem_q) : rem_q);

endmodule

// ----- rtl/core/rv32im_instruction_execute_core.sv -----
// RV32IM execute core: register file and byte data memory in synchronous RAMs.
// Each instruction reads rs1, rs2, a0 and a7, executes, then multiplies, divides, or loads
// or stores byte by byte as needed, and commits once the output is free; one at a time.
// The register-file and memory read ports take one access a cycle; the divider is iterative.
// After reset a clearing pass zeroes the data memory, all MEM_BYTES (16384) bytes of it.
// Depends on rv32ie_pkg, rv32ie_ram and rv32ie_div.
module rv32im_instruction_execute_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [31:0]                     s_axis_tdata,  // instruction
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// instr_pc, next_pc, reg_write, reg_index, reg_value, store_enable, store_address,
	// store_data, store_size, halted, halt_code, illegal, zero pad
	output logic [rv32ie_pkg::OUT_W-1:0]    m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [31:0]                     cfg_data
);
	import rv32ie_pkg::*;

	typedef enum logic [12:0] {
		S_CLEAR  = 13'b0000000000001,
		S_IDLE   = 13'b0000000000010,
		S_RA     = 13'b0000000000100,
		S_RB     = 13'b0000000001000,
		S_RC     = 13'b0000000010000,
		S_RD     = 13'b0000000100000,
		S_EXEC   = 13'b0000001000000,
		S_MUL    = 13'b0000010000000,
		S_DIV    = 13'b0000100000000,
		S_LDA    = 13'b0001000000000,
		S_LDD    = 13'b0010000000000,
		S_ST     = 13'b0100000000000,
		S_COMMIT = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic [31:0] pc_q, base_q, ins_q, a_q, b_q, a0_q, a7_q;
	logic [31:0] mstatus_q, mtvec_q, mepc_q, mcause_q;
	logic        stopped_q;
	logic [31:0] rf_vld_q;
	logic [4:0]  rf_ra_q;
	logic [MEM_AW-1:0] clr_q, off_q;
	logic [1:0]  cnt_q;
	logic [31:0] ld_q;
	logic [63:0] prod_q;

	logic [31:0] val_q, npc_q, addr_q, csr_wd_q;
	logic        wr_q, st_q, ill_q, halt_q, csr_we_q, ecall_q;
	res_src_t    src_q;
	csr_sel_t    csr_sel_q;

	logic [OUT_W-1:0] out_q;
	logic             out_vld_q;

	// register file and data memory ports
	logic        rf_we;
	logic [4:0]  rf_ra;
	logic [31:0] rf_rd, rf_wd, rf_rv;
	logic              dm_we;
	logic [MEM_AW-1:0] dm_wa, dm_ra, dm_byte;
	logic [7:0]        dm_wd, dm_rd;

	div_req_t div_req;
	div_rsp_t div_rsp;

	rv32ie_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
		.clk(clk), .we(rf_we), .waddr(ins_q[11:7]), .wdata(rf_wd),
		.raddr(rf_ra), .rdata(rf_rd)
	);

	rv32ie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dmem (
		.clk(clk), .we(dm_we), .waddr(dm_wa), .wdata(dm_wd),
		.raddr(dm_ra), .rdata(dm_rd)
	);

	rv32ie_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// decode fields
	logic [6:0]  op, f7;
	logic [2:0]  f3;
	logic [4:0]  rd;
	logic [31:0] imm_i, imm_s, imm_b, imm_j;
	logic [1:0]  nlast;

	assign op    = ins_q[6:0];
	assign rd    = ins_q[11:7];
	assign f3    = ins_q[14:12];
	assign f7    = ins_q[31:25];
	assign imm_i = {{20{ins_q[31]}}, ins_q[31:20]};
	assign imm_s = {{20{ins_q[31]}}, ins_q[31:25], ins_q[11:7]};
	assign imm_b = {{20{ins_q[31]}}, ins_q[7], ins_q[30:25], ins_q[11:8], 1'b0};
	assign imm_j = {{12{ins_q[31]}}, ins_q[19:12], ins_q[20], ins_q[30:21], 1'b0};
	assign nlast = {f3[1], f3[1] | f3[0]};

	assign rf_rv = rf_vld_q[rf_ra_q] ? rf_rd : '0;

	always_comb begin
		case (state_q)
			S_IDLE:  rf_ra = s_axis_tdata[19:15];
			S_RA:    rf_ra = ins_q[24:20];
			S_RB:    rf_ra = REG_A0;
			S_RC:    rf_ra = REG_A7;
			default: rf_ra = '0;
		endcase
	end

	// execute
	logic [31:0] e_val, e_npc, e_addr, e_csr_wd, csr_rd;
	logic        e_wr, e_st, e_ill, e_halt, e_ld, e_mul, e_div, e_csr_we, e_ecall;
	logic        csr_hit;
	csr_sel_t    csr_sel;
	res_src_t    e_src;
	logic [4:0]  shamt;

	always_comb begin
		case (ins_q[31:20])
			CSR_MSTATUS: begin csr_hit = 1'b1; csr_sel = CS_MSTATUS; csr_rd = mstatus_q; end
			CSR_MTVEC:   begin csr_hit = 1'b1; csr_sel = CS_MTVEC;   csr_rd = mtvec_q;   end
			CSR_MEPC:    begin csr_hit = 1'b1; csr_sel = CS_MEPC;    csr_rd = mepc_q;    end
			CSR_MCAUSE:  begin csr_hit = 1'b1; csr_sel = CS_MCAUSE;  csr_rd = mcause_q;  end
			default:     begin csr_hit = 1'b0; csr_sel = CS_MSTATUS; csr_rd = '0;        end
		endcase
	end

	always_comb begin
		e_val    = '0;
		e_npc    = pc_q + 32'd4;
		e_wr     = 1'b0;
		e_st     = 1'b0;
		e_ill    = 1'b0;
		e_halt   = 1'b0;
		e_ld     = 1'b0;
		e_mul    = 1'b0;
		e_div    = 1'b0;
		e_csr_we = 1'b0;
		e_csr_wd = '0;
		e_ecall  = 1'b0;
		e_src    = SRC_ALU;
		e_addr   = a_q + ((op == OP_STORE) ? imm_s : imm_i);
		shamt    = (op == OP_IMM) ? ins_q[24:20] : b_q[4:0];
		case (op)
			OP_LUI: begin
				e_wr  = 1'b1;
				e_val = {ins_q[31:12], 12'd0};
			end
			OP_AUIPC: begin
				e_wr  = 1'b1;
				e_val = pc_q + {ins_q[31:12], 12'd0};
			end
			OP_JAL: begin
				e_wr  = 1'b1;
				e_val = pc_q + 32'd4;
				e_npc = pc_q + imm_j;
			end
			OP_JALR: begin
				if (f3 != 3'd0) begin
					e_ill = 1'b1;
				end else begin
					e_wr  = 1'b1;
					e_val = pc_q + 32'd4;
					e_npc = (a_q + imm_i) & ~32'd1;
				end
			end
			OP_BRANCH: begin
				case (f3)
					3'd0: if (a_q == b_q) e_npc = pc_q + imm_b;
					3'd1: if (a_q != b_q) e_npc = pc_q + imm_b;
					3'd4: if ($signed(a_q) < $signed(b_q)) e_npc = pc_q + imm_b;
					3'd5: if (!($signed(a_q) < $signed(b_q))) e_npc = pc_q + imm_b;
					3'd6: if (a_q < b_q) e_npc = pc_q + imm_b;
					3'd7: if (a_q >= b_q) e_npc = pc_q + imm_b;
					default: e_ill = 1'b1;
				endcase
			end
			OP_LOAD: begin
				if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
					e_ill = 1'b1;
				end else begin
					e_wr  = 1'b1;
					e_ld  = 1'b1;
					e_src = SRC_LOAD;
				end
			end
			OP_STORE: begin
				if (f3 > 3'd2) e_ill = 1'b1;
				else e_st = 1'b1;
			end
			OP_IMM: begin
				e_wr = 1'b1;
				case (f3)
					3'd0: e_val = a_q + imm_i;
					3'd2: e_val = {31'd0, $signed(a_q) < $signed(imm_i)};
					3'd3: e_val = {31'd0, a_q < imm_i};
					3'd4: e_val = a_q ^ imm_i;
					3'd6: e_val = a_q | imm_i;
					3'd7: e_val = a_q & imm_i;
					3'd1: begin
						if (f7 == F7_BASE) e_val = a_q << shamt;
						else e_ill = 1'b1;
					end
					default: begin
						if (f7 == F7_BASE) e_val = a_q >> shamt;
						else if (f7 == F7_ALT) e_val = 32'($signed(a_q) >>> shamt);
						else e_ill = 1'b1;
					end
				endcase
			end
			OP_REG: begin
				e_wr = 1'b1;
				if (f7 == F7_MULD) begin
					case (f3)
						3'd0: begin e_mul = 1'b1; e_src = SRC_MUL_LO; end
						3'd1, 3'd3: begin e_mul = 1'b1; e_src = SRC_MUL_HI; end
						3'd4, 3'd5: begin e_div = 1'b1; e_src = SRC_QUO; end
						3'd6, 3'd7: begin e_div = 1'b1; e_src = SRC_REM; end
						default: e_ill = 1'b1;
					endcase
				end else if (f7 == F7_BASE) begin
					case (f3)
						3'd0: e_val = a_q + b_q;
						3'd1: e_val = a_q << shamt;
						3'd2: e_val = {31'd0, $signed(a_q) < $signed(b_q)};
						3'd3: e_val = {31'd0, a_q < b_q};
						3'd4: e_val = a_q ^ b_q;
						3'd5: e_val = a_q >> shamt;
						3'd6: e_val = a_q | b_q;
						default: e_val = a_q & b_q;
					endcase
				end else if (f7 == F7_ALT && f3 == 3'd0) begin
					e_val = a_q - b_q;
				end else if (f7 == F7_ALT && f3 == 3'd5) begin
					e_val = 32'($signed(a_q) >>> shamt);
				end else begin
					e_ill = 1'b1;
				end
			end
			OP_SYSTEM: begin
				if (f3 == 3'd1 || f3 == 3'd2) begin
					e_wr     = 1'b1;
					e_val    = csr_rd;
					e_csr_we = csr_hit;
					e_csr_wd = (f3 == 3'd1) ? a_q : (csr_rd | a_q);
				end else if (ins_q == INSN_EBREAK) begin
					e_halt = 1'b1;
				end else if (ins_q == INSN_ECALL) begin
					e_ecall = 1'b1;
					e_npc   = mtvec_q;
				end else if (ins_q == INSN_MRET) begin
					e_npc = mepc_q;
				end else begin
					e_ill = 1'b1;
				end
			end
			default: e_ill = 1'b1;
		endcase
		if (e_ill) begin
			e_wr     = 1'b0;
			e_halt   = 1'b1;
			e_st     = 1'b0;
			e_ld     = 1'b0;
			e_mul    = 1'b0;
			e_div    = 1'b0;
			e_csr_we = 1'b0;
			e_ecall  = 1'b0;
		end
	end

	assign div_req.start = (state_q == S_EXEC) && !stopped_q && e_div;
	assign div_req.sgn   = ~f3[0];
	assign div_req.a     = a_q;
	assign div_req.b     = b_q;

	// final result value
	logic [31:0] fin_val, ld_ext;

	always_comb begin
		case (f3)
			3'd0:    ld_ext = {{24{ld_q[7]}}, ld_q[7:0]};
			3'd1:    ld_ext = {{16{ld_q[15]}}, ld_q[15:0]};
			3'd4:    ld_ext = {24'd0, ld_q[7:0]};
			3'd5:    ld_ext = {16'd0, ld_q[15:0]};
			default: ld_ext = ld_q;
		endcase
		case (src_q)
			SRC_LOAD:   fin_val = ld_ext;
			SRC_MUL_LO: fin_val = prod_q[31:0];
			SRC_MUL_HI: fin_val = prod_q[63:32];
			SRC_QUO:    fin_val = div_rsp.quo;
			SRC_REM:    fin_val = div_rsp.rem;
			default:    fin_val = val_q;
		endcase
	end

	logic out_free, commit, rf_wen;
	logic [65:0] prod;

	assign out_free = !out_vld_q || m_axis_tready;
	assign commit   = (state_q == S_COMMIT) && out_free;
	assign rf_wen   = wr_q && (rd != 5'd0);
	assign rf_we    = commit && rf_wen;
	assign rf_wd    = fin_val;
	assign prod     = 66'($signed({~f3[1] & a_q[31], a_q}) * $signed({f3[1:0] == 2'b01 & b_q[31], b_q}));

	assign dm_byte = off_q + MEM_AW'(cnt_q);
	assign dm_ra   = dm_byte;
	assign dm_we   = (state_q == S_CLEAR) || (state_q == S_ST);
	assign dm_wa   = (state_q == S_CLEAR) ? clr_q : dm_byte;
	assign dm_wd   = (state_q == S_CLEAR) ? 8'd0 : b_q[8*cnt_q +: 8];

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			pc_q      <= RESET_PC;
			base_q    <= RESET_BASE;
			mstatus_q <= '0;
			mtvec_q   <= '0;
			mepc_q    <= '0;
			mcause_q  <= '0;
			stopped_q <= 1'b0;
			rf_vld_q  <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_vld_q && m_axis_tready && !commit) out_vld_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + MEM_AW'(1);
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE:  if (s_axis_tvalid) state_q <= S_RA;
				S_RA:    state_q <= S_RB;
				S_RB:    state_q <= S_RC;
				S_RC:    state_q <= S_RD;
				S_RD:    state_q <= S_EXEC;
				S_EXEC: begin
					if (stopped_q)  state_q <= S_COMMIT;
					else if (e_ld)  state_q <= S_LDA;
					else if (e_st)  state_q <= S_ST;
					else if (e_mul) state_q <= S_MUL;
					else if (e_div) state_q <= S_DIV;
					else            state_q <= S_COMMIT;
				end
				S_MUL:   state_q <= S_COMMIT;
				S_DIV:   if (div_rsp.done) state_q <= S_COMMIT;
				S_LDA:   state_q <= S_LDD;
				S_LDD:   state_q <= (cnt_q == nlast) ? S_COMMIT : S_LDA;
				S_ST:    if (cnt_q == nlast) state_q <= S_COMMIT;
				S_COMMIT: begin
					if (out_free) begin
						state_q   <= S_IDLE;
						out_vld_q <= 1'b1;
						pc_q      <= npc_q;
						if (halt_q) stopped_q <= 1'b1;
						if (rf_wen) rf_vld_q[rd] <= 1'b1;
						if (ecall_q) begin
							mepc_q   <= pc_q;
							mcause_q <= a7_q;
						end
						if (csr_we_q) begin
							case (csr_sel_q)
								CS_MSTATUS: mstatus_q <= csr_wd_q;
								CS_MTVEC:   mtvec_q   <= csr_wd_q;
								CS_MEPC:    mepc_q    <= csr_wd_q;
								CS_MCAUSE:  mcause_q  <= csr_wd_q;
								default:    mstatus_q <= mstatus_q;
							endcase
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_valid) begin
				if (cfg_index == CFG_START_PC) pc_q <= cfg_data;
				else base_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		rf_ra_q <= rf_ra;
		case (state_q)
			S_IDLE: ins_q <= s_axis_tdata;
			S_RA:   a_q   <= rf_rv;
			S_RB:   b_q   <= rf_rv;
			S_RC:   a0_q  <= rf_rv;
			S_RD:   a7_q  <= rf_rv;
			S_EXEC: begin
				cnt_q     <= '0;
				ld_q      <= '0;
				addr_q    <= e_addr;
				off_q     <= MEM_AW'(e_addr - base_q);
				src_q     <= e_src;
				csr_sel_q <= csr_sel;
				csr_wd_q  <= e_csr_wd;
				if (stopped_q) begin
					val_q    <= '0;
					npc_q    <= pc_q;
					wr_q     <= 1'b0;
					st_q     <= 1'b0;
					ill_q    <= 1'b0;
					halt_q   <= 1'b1;
					csr_we_q <= 1'b0;
					ecall_q  <= 1'b0;
				end else begin
					val_q    <= e_val;
					npc_q    <= e_npc;
					wr_q     <= e_wr;
					st_q     <= e_st;
					ill_q    <= e_ill;
					halt_q   <= e_halt;
					csr_we_q <= e_csr_we;
					ecall_q  <= e_ecall;
				end
			end
			S_MUL:  prod_q <= prod[63:0];
			S_LDD: begin
				ld_q[8*cnt_q +: 8] <= dm_rd;
				cnt_q <= cnt_q + 2'd1;
			end
			S_ST:   cnt_q <= cnt_q + 2'd1;
			S_COMMIT: begin
				if (out_free) begin
					out_q[31:0]      <= pc_q;
					out_q[63:32]     <= npc_q;
					out_q[64]        <= rf_wen;
					out_q[69:65]     <= rf_wen ? rd : 5'd0;
					out_q[101:70]    <= rf_wen ? fin_val : 32'd0;
					out_q[102]       <= st_q;
					out_q[134:103]   <= st_q ? addr_q : 32'd0;
					out_q[166:135]   <= st_q ? b_q : 32'd0;
					out_q[168:167]   <= st_q ? f3[1:0] : 2'd0;
					out_q[169]       <= halt_q;
					out_q[201:170]   <= halt_q ? a0_q : 32'd0;
					out_q[202]       <= ill_q;
					out_q[OUT_W-1:203] <= '0;
				end
			end
			default: ;
		endcase
	end

endmodule
